/* sv/vna_pkg.sv */
// ----------------------------------------------------------------------------
// vna_pkg - shared types and codes of the vertex normal accumulation unit
// Request and status codes, register indexes, the queued word between the
// front and back ends, and the result word.
// ----------------------------------------------------------------------------
package vna_pkg;

  // default mesh capacity
  localparam int unsigned DEF_MAX_VERTICES = 1024;
  localparam int unsigned DEF_MAX_FACES    = 2048;

  // per-component sum width, for sums of Q1.14 face normals
  localparam int unsigned SUM_W = 20;

  // request kinds as carried in tuser
  typedef enum logic [1:0] {
    REQ_POS     = 2'd0,
    REQ_TRI     = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] CFG_FACE_COUNT   = 2'd1;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_POS,
    OP_TRI,
    OP_COMPUTE,
    OP_READ,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [10:0] slot;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } item_t;

  // head of the front-end queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef logic signed [62:0] wide_t;
  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    logic [1:0] status;
    q14_t       nz;
    q14_t       ny;
    q14_t       nx;
  } res_t;

endpackage

/* sv/vertex_normal_accumulation_unit.sv */
// ----------------------------------------------------------------------------
// vertex_normal_accumulation_unit - area-unweighted vertex normals
// Mesh store with a compute pass that accumulates unit face normals per
// vertex and stores negated, normalised Q1.14 vertex normals.
// ----------------------------------------------------------------------------
// Every request word gives one result word. Position and triangle loads and
// rejected words are taken one per cycle while the result register is free; a
// normal read passes through an extra read state in the back end because of
// the registered read of the normal memory. Normals read as zero until the
// first compute pass, which writes every entry. A compute pass clears the
// sums up to vertex_count, then walks the faces, skipping a face if a corner
// lies beyond vertex_count and otherwise taking its cross product and
// running the normaliser, then walks the vertices, writing zero beyond
// vertex_count and otherwise running the normaliser. The normaliser run
// (shift search one bit a cycle, three squares, 31-step square root, a
// division per component) sets the length of the pass. A two-word queue
// keeps taking requests while the back end works or a result waits.
// ----------------------------------------------------------------------------
module vertex_normal_accumulation_unit import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_FACES    = DEF_MAX_FACES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot_index[10:0], value_a[42:11], value_b[74:43], value_c[106:75], zero pad
  input  logic [111:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32], status[49:48], zero pad
  output logic [55:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [11:0]  cfg_data_i
);

  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned FCW = $clog2(MAX_FACES + 1);

  logic [10:0]    vertex_count_q;
  logic [11:0]    face_count_q;
  logic [31:0]    vc_w, fc_w;
  logic [VCW-1:0] vc_eff;
  logic [FCW-1:0] fc_eff;
  head_t          head;
  logic           pop;
  res_t           res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
      face_count_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[10:0];
        CFG_FACE_COUNT:   face_count_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counts clipped to capacity
  always_comb begin
    vc_w   = (32'(vertex_count_q) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                       : 32'(vertex_count_q);
    fc_w   = (32'(face_count_q) > 32'(MAX_FACES)) ? 32'(MAX_FACES)
                                                  : 32'(face_count_q);
    vc_eff = vc_w[VCW-1:0];
    fc_eff = fc_w[FCW-1:0];
  end

  vna_front #(.MAX_VERTICES(MAX_VERTICES), .MAX_FACES(MAX_FACES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .slot_index_i (s_axis_tdata[10:0]),
    .value_a_i    (s_axis_tdata[42:11]),
    .value_b_i    (s_axis_tdata[74:43]),
    .value_c_i    (s_axis_tdata[106:75]),
    .head_o       (head),
    .pop_i        (pop)
  );

  vna_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_FACES(MAX_FACES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .vc_i        (vc_eff),
    .fc_i        (fc_eff),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {6'd0, res.status, res.nz, res.ny, res.nx};

endmodule

/* sv/vna_ram.sv */
// ----------------------------------------------------------------------------
// vna_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/vna_front.sv */
// ----------------------------------------------------------------------------
// vna_front - request intake and classification
// Checks slot and corner ranges, tags each word with its operation and holds
// it in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_FACES    = DEF_MAX_FACES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [10:0] slot_index_i,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  input  logic [31:0] value_c_i,
  output head_t       head_o,
  input  logic        pop_i
);

  item_t       cls;
  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic [31:0] slot_w;
  logic        bad_corner;

  // range checks and operation tag
  always_comb begin
    slot_w     = 32'(slot_index_i);
    bad_corner = value_a_i[31] || (value_a_i >= 32'(MAX_VERTICES)) ||
                 value_b_i[31] || (value_b_i >= 32'(MAX_VERTICES)) ||
                 value_c_i[31] || (value_c_i >= 32'(MAX_VERTICES));
    cls.slot   = slot_index_i;
    cls.a      = value_a_i;
    cls.b      = value_b_i;
    cls.c      = value_c_i;
    unique case (req_e'(req_type_i))
      REQ_POS:     cls.op = (slot_w >= 32'(MAX_VERTICES)) ? OP_REJECT : OP_POS;
      REQ_TRI:     cls.op = ((slot_w >= 32'(MAX_FACES)) || bad_corner) ? OP_REJECT : OP_TRI;
      REQ_COMPUTE: cls.op = OP_COMPUTE;
      REQ_READ:    cls.op = (slot_w >= 32'(MAX_VERTICES)) ? OP_REJECT : OP_READ;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

/* sv/vna_unit3.sv */
// ----------------------------------------------------------------------------
// vna_unit3 - iterative vector normaliser
// Scales a 3-vector so its largest magnitude sits in [2^29, 2^30), takes the
// integer square root of the sum of squares and divides each component by
// it with rounding, giving Q1.14. A zero vector gives zero.
// ----------------------------------------------------------------------------
module vna_unit3 import vna_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  wide_t vec_i  [3],
  output logic  done_o,
  output q14_t  unit_o [3]
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_SQRT,
    U_DSET,
    U_DSTEP
  } ustate_e;

  ustate_e     state_q;
  logic        done_q;
  logic [2:0]  k_q;
  logic [3:0]  it_q;
  logic [61:0] m_q [3];
  logic        sg_q [3];
  logic [59:0] prod_q;
  logic [61:0] sq_q, x_q, r_q, bit_q;
  logic [30:0] len_q, rem_q;
  logic [14:0] n_q, qt_q;
  q14_t        out_q [3];

  logic [61:0] orv;
  logic [61:0] sqt;
  logic [29:0] sq_op;
  logic [1:0]  kc;
  logic [44:0] num;
  logic [31:0] dt;
  logic        ge;
  logic [14:0] qfin;

  always_comb begin
    orv  = m_q[0] | m_q[1] | m_q[2];
    sqt  = r_q + bit_q;
    kc   = k_q[1:0];
    case (kc)
      2'd0:    sq_op = m_q[0][29:0];
      2'd1:    sq_op = m_q[1][29:0];
      default: sq_op = m_q[2][29:0];
    endcase
    num  = {1'b0, sq_op, 14'd0} + 45'(len_q >> 1);
    dt   = {rem_q, n_q[14]};
    ge   = (dt >= {1'b0, len_q});
    qfin = {qt_q[13:0], ge};
  end

  // sequencer with its registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
      k_q     <= 3'd0;
      it_q    <= 4'd0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          if (start_i) begin
            state_q <= U_NORM;
          end
        end
        U_NORM: begin
          if (orv == '0) begin
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end else if ((orv[61:30] == '0) && orv[29]) begin
            k_q     <= 3'd0;
            state_q <= U_SQ;
          end
        end
        U_SQ: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd3) begin
            state_q <= U_SQRT;
          end
        end
        U_SQRT: begin
          if (bit_q[0]) begin
            k_q     <= 3'd0;
            state_q <= U_DSET;
          end
        end
        U_DSET: begin
          it_q    <= 4'd0;
          state_q <= U_DSTEP;
        end
        U_DSTEP: begin
          it_q <= it_q + 4'd1;
          if (it_q == 4'd14) begin
            if (k_q == 3'd2) begin
              done_q  <= 1'b1;
              state_q <= U_IDLE;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= U_DSET;
            end
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            sg_q[i] <= vec_i[i][62];
            m_q[i]  <= vec_i[i][62] ? 62'(-vec_i[i]) : 62'(vec_i[i]);
          end
        end
      end
      U_NORM: begin
        if (orv == '0) begin
          for (int i = 0; i < 3; i++) out_q[i] <= '0;
        end else if (orv[61:30] != '0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (!orv[29]) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
        sq_q <= '0;
      end
      U_SQ: begin
        // one square a cycle, accumulated in the cycle after
        if (k_q != 3'd3) begin
          prod_q <= sq_op * sq_op;
        end
        if (k_q == 3'd3) begin
          x_q   <= sq_q + 62'(prod_q);
          r_q   <= '0;
          bit_q <= 62'(1) << 60;
        end else if (k_q != 3'd0) begin
          sq_q <= sq_q + 62'(prod_q);
        end
      end
      U_SQRT: begin
        // digit-by-digit square root of x
        if (x_q >= sqt) begin
          x_q <= x_q - sqt;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          len_q <= (x_q >= sqt) ? 31'((r_q >> 1) + bit_q) : 31'(r_q >> 1);
        end
      end
      U_DSET: begin
        rem_q <= {1'b0, num[44:15]};
        n_q   <= num[14:0];
        qt_q  <= '0;
      end
      U_DSTEP: begin
        rem_q <= ge ? 31'(dt - {1'b0, len_q}) : dt[30:0];
        n_q   <= n_q << 1;
        qt_q  <= qfin;
        if (it_q == 4'd14) begin
          case (kc)
            2'd0:    out_q[0] <= sg_q[0] ? -q14_t'(qfin) : q14_t'(qfin);
            2'd1:    out_q[1] <= sg_q[1] ? -q14_t'(qfin) : q14_t'(qfin);
            default: out_q[2] <= sg_q[2] ? -q14_t'(qfin) : q14_t'(qfin);
          endcase
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign unit_o = out_q;

endmodule

/* sv/vna_back.sv */
// ----------------------------------------------------------------------------
// vna_back - execution of queued requests
// Owns the mesh and normal memories, writes loads, answers reads and runs
// the compute pass: sum clear, face walk with cross product and scatter,
// then the vertex walk that normalises and stores each normal, zero beyond vertex_count.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_FACES    = DEF_MAX_FACES,
  localparam int unsigned VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int unsigned FW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1,
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1),
  localparam int unsigned FCW = $clog2(MAX_FACES + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  head_t          head_i,
  output logic           pop_o,
  input  logic [VCW-1:0] vc_i,
  input  logic [FCW-1:0] fc_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output res_t           res_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_CLR, S_FRD, S_FTRI, S_P0, S_P1, S_P2, S_EDGE, S_MUL,
    S_FGO, S_FUNIT, S_ARD, S_AWR, S_VRD, S_VDAT, S_VUNIT, S_DONE
  } state_e;

  state_e          state_q;
  logic            out_valid_q;
  res_t            res_q;
  logic            nvalid_q;
  logic [VCW-1:0]  vi_q;
  logic [FCW-1:0]  fi_q;
  logic [1:0]      ck_q;
  logic [2:0]      mk_q;

  logic [VW-1:0]      tri_q [3];
  logic signed [31:0] p_q [3][3];
  logic signed [30:0] a_q [3];
  logic signed [30:0] b_q [3];
  logic signed [61:0] prod_q;
  wide_t              c_q [3];
  q14_t               fn_q [3];

  // memory ports
  logic               pos_we, pos_re;
  logic [VW-1:0]      pos_waddr, pos_raddr;
  logic [95:0]        pos_rdata;
  logic               tri_we, tri_re;
  logic [FW-1:0]      tri_waddr;
  logic [3*VW-1:0]    tri_wdata, tri_rdata;
  logic               sum_we, sum_re;
  logic [VW-1:0]      sum_waddr, sum_raddr;
  logic [3*SUM_W-1:0] sum_wdata, sum_rdata;
  logic               nrm_we, nrm_re;
  logic [VW-1:0]      nrm_raddr;
  logic [47:0]        nrm_wdata, nrm_rdata;

  logic               out_free, take;
  op_e                op;
  logic [31:0]        slot_w;
  logic [VW-1:0]      cor [3];
  logic               cor_ok, vi_in, fi_in, vi_last;
  logic               u_start, u_done;
  wide_t              u_vec [3];
  q14_t               u_out [3];

  logic signed [32:0] da [3], db [3];
  logic [32:0]        ma [3], mb [3], sa [3], sb [3];
  logic [32:0]        eor;
  logic [1:0]         esh;
  logic signed [30:0] an [3], bn [3];
  logic signed [30:0] mul_x, mul_y;
  logic signed [61:0] mul_p;
  logic signed [SUM_W:0] s21 [3];
  logic [SUM_W-1:0]   sat [3];

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = (state_q == S_IDLE) && head_i.valid && out_free;
  assign op       = head_i.item.op;
  assign slot_w   = 32'(head_i.item.slot);
  assign pop_o    = take;
  assign vi_in    = (vi_q < vc_i);
  assign fi_in    = (fi_q < fc_i);
  assign vi_last  = (vi_q == VCW'(MAX_VERTICES - 1));

  // corner fetch and range test against vertex_count
  always_comb begin
    for (int k = 0; k < 3; k++) cor[k] = tri_rdata[k*VW +: VW];
    cor_ok = (32'(cor[0]) < 32'(vc_i)) && (32'(cor[1]) < 32'(vc_i)) &&
             (32'(cor[2]) < 32'(vc_i));
  end

  // edge vectors, scaled together below 2^30
  always_comb begin
    eor = '0;
    for (int i = 0; i < 3; i++) begin
      da[i] = {p_q[1][i][31], p_q[1][i]} - {p_q[0][i][31], p_q[0][i]};
      db[i] = {p_q[2][i][31], p_q[2][i]} - {p_q[1][i][31], p_q[1][i]};
      ma[i] = da[i][32] ? 33'(-da[i]) : 33'(da[i]);
      mb[i] = db[i][32] ? 33'(-db[i]) : 33'(db[i]);
      eor   = eor | ma[i] | mb[i];
    end
    esh = eor[32] ? 2'd3 : (eor[31] ? 2'd2 : (eor[30] ? 2'd1 : 2'd0));
    for (int i = 0; i < 3; i++) begin
      sa[i] = ma[i] >> esh;
      sb[i] = mb[i] >> esh;
      an[i] = da[i][32] ? -$signed(sa[i][30:0]) : $signed(sa[i][30:0]);
      bn[i] = db[i][32] ? -$signed(sb[i][30:0]) : $signed(sb[i][30:0]);
    end
  end

  // shared cross-product multiplier
  always_comb begin
    case (mk_q)
      3'd0:    begin mul_x = a_q[1]; mul_y = b_q[2]; end
      3'd1:    begin mul_x = a_q[2]; mul_y = b_q[1]; end
      3'd2:    begin mul_x = a_q[2]; mul_y = b_q[0]; end
      3'd3:    begin mul_x = a_q[0]; mul_y = b_q[2]; end
      3'd4:    begin mul_x = a_q[0]; mul_y = b_q[1]; end
      default: begin mul_x = a_q[1]; mul_y = b_q[0]; end
    endcase
    mul_p = mul_x * mul_y;
  end

  // saturating add of the face normal to a corner sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s21[i] = $signed({sum_rdata[i*SUM_W + SUM_W - 1], sum_rdata[i*SUM_W +: SUM_W]}) +
               (SUM_W + 1)'(fn_q[i]);
      if (s21[i][SUM_W] != s21[i][SUM_W-1]) begin
        sat[i] = s21[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sat[i] = s21[i][SUM_W-1:0];
      end
    end
  end

  // normaliser source
  always_comb begin
    u_start = (state_q == S_FGO) || (state_q == S_VDAT);
    for (int i = 0; i < 3; i++) begin
      u_vec[i] = (state_q == S_FGO) ? c_q[i] :
                 wide_t'($signed(sum_rdata[i*SUM_W +: SUM_W]));
    end
  end

  // memory controls
  always_comb begin
    pos_we    = take && (op == OP_POS);
    pos_waddr = slot_w[VW-1:0];
    tri_we    = take && (op == OP_TRI);
    tri_waddr = slot_w[FW-1:0];
    tri_wdata = {head_i.item.c[VW-1:0], head_i.item.b[VW-1:0], head_i.item.a[VW-1:0]};
    tri_re    = (state_q == S_FRD) && fi_in;
    nrm_re    = take && (op == OP_READ);
    nrm_raddr = slot_w[VW-1:0];

    pos_re    = 1'b0;
    pos_raddr = tri_q[0];
    case (state_q)
      S_FTRI: begin pos_re = cor_ok; pos_raddr = cor[0];   end
      S_P0:   begin pos_re = 1'b1;   pos_raddr = tri_q[1]; end
      S_P1:   begin pos_re = 1'b1;   pos_raddr = tri_q[2]; end
      default: ;
    endcase

    sum_we    = 1'b0;
    sum_re    = 1'b0;
    sum_waddr = vi_q[VW-1:0];
    sum_raddr = vi_q[VW-1:0];
    sum_wdata = '0;
    case (state_q)
      S_CLR: sum_we = vi_in;
      S_ARD: begin
        sum_re    = 1'b1;
        sum_raddr = tri_q[ck_q];
      end
      S_AWR: begin
        sum_we    = 1'b1;
        sum_waddr = tri_q[ck_q];
        sum_wdata = {sat[2], sat[1], sat[0]};
      end
      S_VRD: sum_re = vi_in;
      default: ;
    endcase

    nrm_we    = ((state_q == S_VRD) && !vi_in) || ((state_q == S_VUNIT) && u_done);
    nrm_wdata = (state_q == S_VUNIT) ? {-u_out[2], -u_out[1], -u_out[0]} : '0;
  end

  // sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      nvalid_q    <= 1'b0;
      vi_q        <= '0;
      fi_q        <= '0;
      ck_q        <= 2'd0;
      mk_q        <= 3'd0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            case (op)
              OP_POS, OP_TRI: begin
                res_q       <= '{status: ST_OK, default: '0};
                out_valid_q <= 1'b1;
              end
              OP_REJECT: begin
                res_q       <= '{status: ST_RANGE, default: '0};
                out_valid_q <= 1'b1;
              end
              OP_READ: state_q <= S_READ;
              default: begin
                vi_q    <= '0;
                state_q <= S_CLR;
              end
            endcase
          end
        end
        S_READ: begin
          res_q.status <= ST_OK;
          res_q.nx     <= nvalid_q ? q14_t'(nrm_rdata[15:0])  : '0;
          res_q.ny     <= nvalid_q ? q14_t'(nrm_rdata[31:16]) : '0;
          res_q.nz     <= nvalid_q ? q14_t'(nrm_rdata[47:32]) : '0;
          out_valid_q  <= 1'b1;
          state_q      <= S_IDLE;
        end
        S_CLR: begin
          if (vi_in) begin
            vi_q <= vi_q + VCW'(1);
          end else begin
            fi_q    <= '0;
            state_q <= S_FRD;
          end
        end
        S_FRD: begin
          if (fi_in) begin
            state_q <= S_FTRI;
          end else begin
            vi_q    <= '0;
            state_q <= S_VRD;
          end
        end
        S_FTRI: begin
          if (cor_ok) begin
            state_q <= S_P0;
          end else begin
            fi_q    <= fi_q + FCW'(1);
            state_q <= S_FRD;
          end
        end
        S_P0: state_q <= S_P1;
        S_P1: state_q <= S_P2;
        S_P2: state_q <= S_EDGE;
        S_EDGE: begin
          mk_q    <= 3'd0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          mk_q <= mk_q + 3'd1;
          if (mk_q == 3'd6) begin
            state_q <= S_FGO;
          end
        end
        S_FGO: state_q <= S_FUNIT;
        S_FUNIT: begin
          if (u_done) begin
            ck_q    <= 2'd0;
            state_q <= S_ARD;
          end
        end
        S_ARD: state_q <= S_AWR;
        S_AWR: begin
          if (ck_q == 2'd2) begin
            fi_q    <= fi_q + FCW'(1);
            state_q <= S_FRD;
          end else begin
            ck_q    <= ck_q + 2'd1;
            state_q <= S_ARD;
          end
        end
        S_VRD: begin
          if (vi_in) begin
            state_q <= S_VDAT;
          end else if (vi_last) begin
            nvalid_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            vi_q <= vi_q + VCW'(1);
          end
        end
        S_VDAT: state_q <= S_VUNIT;
        S_VUNIT: begin
          if (u_done) begin
            if (vi_last) begin
              nvalid_q <= 1'b1;
              state_q  <= S_DONE;
            end else begin
              vi_q    <= vi_q + VCW'(1);
              state_q <= S_VRD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_q       <= '{status: ST_DONE, default: '0};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // face datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_FTRI: tri_q <= cor;
      S_P0: begin
        for (int i = 0; i < 3; i++) p_q[0][i] <= $signed(pos_rdata[i*32 +: 32]);
      end
      S_P1: begin
        for (int i = 0; i < 3; i++) p_q[1][i] <= $signed(pos_rdata[i*32 +: 32]);
      end
      S_P2: begin
        for (int i = 0; i < 3; i++) p_q[2][i] <= $signed(pos_rdata[i*32 +: 32]);
      end
      S_EDGE: begin
        a_q <= an;
        b_q <= bn;
        for (int i = 0; i < 3; i++) c_q[i] <= '0;
      end
      S_MUL: begin
        // product k lands in c[k/2] in the cycle after, odd ones subtracted
        if (mk_q != 3'd6) begin
          prod_q <= mul_p;
        end
        case (mk_q)
          3'd1: c_q[0] <= c_q[0] + wide_t'(prod_q);
          3'd2: c_q[0] <= c_q[0] - wide_t'(prod_q);
          3'd3: c_q[1] <= c_q[1] + wide_t'(prod_q);
          3'd4: c_q[1] <= c_q[1] - wide_t'(prod_q);
          3'd5: c_q[2] <= c_q[2] + wide_t'(prod_q);
          3'd6: c_q[2] <= c_q[2] - wide_t'(prod_q);
          default: ;
        endcase
      end
      S_FUNIT: begin
        if (u_done) begin
          fn_q <= u_out;
        end
      end
      default: ;
    endcase
  end

  vna_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i ({head_i.item.c, head_i.item.b, head_i.item.a}),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  vna_ram #(.WIDTH(3*VW), .DEPTH(MAX_FACES)) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .waddr_i (tri_waddr),
    .wdata_i (tri_wdata),
    .re_i    (tri_re),
    .raddr_i (fi_q[FW-1:0]),
    .rdata_o (tri_rdata)
  );

  vna_ram #(.WIDTH(3*SUM_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  vna_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_nrm_ram (
    .clk_i   (clk_i),
    .we_i    (nrm_we),
    .waddr_i (vi_q[VW-1:0]),
    .wdata_i (nrm_wdata),
    .re_i    (nrm_re),
    .raddr_i (nrm_raddr),
    .rdata_o (nrm_rdata)
  );

  vna_unit3 u_unit3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (u_start),
    .vec_i   (u_vec),
    .done_o  (u_done),
    .unit_o  (u_out)
  );

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // read-modify-write of a sum never overlaps its own read
  a_sum_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_we |-> !sum_re)
    else $error("sum memory read and written in one cycle");

  // the normaliser only finishes while the sequencer waits on it
  a_unit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (state_q == S_FUNIT || state_q == S_VUNIT))
    else $error("normaliser finished outside a wait state");

  // read data lands in a free result register
  a_read_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (op == OP_READ) |=> !out_valid_q)
    else $error("read result would overwrite a pending word");

endmodule
